// ===== src/fir_hilbert_transformer_defines.svh =====
// assertion helpers for the hilbert transformer
`ifndef FIR_HILBERT_TRANSFORMER_DEFINES_SVH
`define FIR_HILBERT_TRANSFORMER_DEFINES_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define HILB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hilbert transformer check failed");

// checked on every edge, reset included
`define HILB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hilbert transformer check failed");

`else

`define HILB_ASSERT(lbl, clk, rst_n, prop)
`define HILB_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ===== src/hilb_pkg.sv =====
`timescale 1ns / 1ps

package hilb_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int TAP_COUNT     = 100;
    localparam int HALF_TAPS     = 50;
    localparam int DIRECT_LAG    = 99;
    localparam int ROM_FRAC      = 17;
    localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((2 * SAMPLE_BITS + 7) / 8) * 8;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    // first half of the antisymmetric response, Q1.17; second half is the negated mirror
    localparam int COEF_ROM [HALF_TAPS] = '{
        106, 111, 118, 128, 142, 158, 178, 201, 227, 258,
        293, 332, 375, 423, 476, 535, 598, 668, 743, 825,
        915, 1011, 1115, 1228, 1351, 1483, 1627, 1782, 1952, 2137,
        2339, 2560, 2804, 3075, 3376, 3715, 4098, 4537, 5044, 5639,
        6350, 7216, 8300, 9701, 11592, 14298, 18517, 26066, 43601, 131042
    };

    // coefficient of tap k rescaled to Q1.(coef_bits-1), rounding half away from zero
    function automatic int coef_at(input int k, input int coef_bits);
        int  c;
        int  mag;
        bit  neg;
        if (k < HALF_TAPS) begin
            c = COEF_ROM[k];
        end else if (k < 2 * HALF_TAPS) begin
            c = -COEF_ROM[2 * HALF_TAPS - 1 - k];
        end else begin
            c = 0;
        end
        neg = (c < 0);
        mag = neg ? -c : c;
        if (coef_bits - 1 > ROM_FRAC) begin
            mag = mag << (coef_bits - 1 - ROM_FRAC);
        end else if (coef_bits - 1 < ROM_FRAC) begin
            mag = (mag + (1 << (ROM_FRAC - coef_bits))) >> (ROM_FRAC + 1 - coef_bits);
        end
        return neg ? -mag : mag;
    endfunction

endpackage

// ===== src/hilb_cell.sv =====
`timescale 1ns / 1ps

// one tap of the transposed chain: two sum stages, then multiply-add with the broadcast word
module hilb_cell #(
    parameter int COEF_BITS = 18,
    parameter int ACC_BITS  = 46,
    parameter logic signed [COEF_BITS-1:0] COEF     = '0,
    parameter logic signed [ACC_BITS-1:0]  ACC_INIT = '0
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  hilb_pkg::t_sample          i_sample,
    input  logic signed [ACC_BITS-1:0] i_sum,
    output logic signed [ACC_BITS-1:0] o_sum
);

    localparam int PROD_BITS = hilb_pkg::SAMPLE_BITS + COEF_BITS;

    logic signed [ACC_BITS-1:0]  r_d1;
    logic signed [ACC_BITS-1:0]  r_d2;
    logic signed [PROD_BITS-1:0] w_prod;

    // two sum stages per cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= ACC_INIT;
            r_d2 <= ACC_INIT;
        end else if (i_en) begin
            r_d1 <= i_sum;
            r_d2 <= r_d1;
        end
    end

    assign w_prod = PROD_BITS'(i_sample) * PROD_BITS'(COEF);
    assign o_sum  = ACC_BITS'(w_prod) + r_d2;

endmodule

// ===== src/hilb_delay.sv =====
`timescale 1ns / 1ps

// in-phase path: shift line matched to the center of the filter
module hilb_delay (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  hilb_pkg::t_sample i_sample,
    output hilb_pkg::t_sample o_tap
);

    hilb_pkg::t_sample r_line [hilb_pkg::DIRECT_LAG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < hilb_pkg::DIRECT_LAG; i++) begin
                r_line[i] <= '0;
            end
        end else if (i_en) begin
            r_line[0] <= i_sample;
            for (int i = 1; i < hilb_pkg::DIRECT_LAG; i++) begin
                r_line[i] <= r_line[i-1];
            end
        end
    end

    // oldest entry is the word accepted DIRECT_LAG words ago
    assign o_tap = r_line[hilb_pkg::DIRECT_LAG-1];

endmodule

// ===== src/fir_hilbert_transformer.sv =====
`timescale 1ns / 1ps
// channel   | dir | handshake            | payload
// ----------+-----+----------------------+-------------------------------------------
// sample in | in  | i_s_tvalid/o_s_tready | i_s_tdata: sample_in
// result    | out | o_m_tvalid/i_m_tready | o_m_tdata: direct_out, quadrature_out
//
// one word per cycle unless stalled; each result is registered as its word is accepted.
// quadrature comes from a 100-cell transposed chain (one multiply-add per cell, two
// sum stages between cells); direct comes from a 99-stage shift line.
// synchronous reset clears both chains to the empty-history state; no clearing pass.
// while the output register is full and not taken, no word is accepted and the chains hold.

`include "fir_hilbert_transformer_defines.svh"

module fir_hilbert_transformer #(
    parameter int COEF_BITS = 18
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [hilb_pkg::IN_DATA_BITS-1:0]  i_s_tdata,  // [23:0] sample_in
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [hilb_pkg::OUT_DATA_BITS-1:0] o_m_tdata   // [23:0] direct_out, [47:24] quadrature_out
);

    localparam int SB       = hilb_pkg::SAMPLE_BITS;
    localparam int TAPS     = hilb_pkg::TAP_COUNT;
    localparam int FRAC     = COEF_BITS - 1;
    localparam int ACC_BITS = SB + COEF_BITS + 4;
    // round-half-up offset enters at the far end of the chain
    localparam logic signed [ACC_BITS-1:0] ROUND_INIT = ACC_BITS'(1 << (FRAC - 1));
    localparam logic signed [ACC_BITS-1:0] QMAX       = ACC_BITS'((1 << (SB - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] QMIN       = -QMAX - ACC_BITS'(1);

    logic                        w_accept;
    hilb_pkg::t_sample           w_sample;
    hilb_pkg::t_sample           w_direct;
    hilb_pkg::t_sample           w_quad;
    logic signed [ACC_BITS-1:0]  w_sum [TAPS+1];
    logic signed [ACC_BITS-1:0]  w_shift;

    logic                        r_valid;
    hilb_pkg::t_sample           r_direct;
    hilb_pkg::t_sample           r_quad;

    assign o_s_tready = !r_valid || i_m_tready;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_sample   = i_s_tdata[SB-1:0];

    assign w_sum[TAPS] = ROUND_INIT;

    for (genvar g = 0; g < TAPS; g++) begin : g_cell
        hilb_cell #(
            .COEF_BITS (COEF_BITS),
            .ACC_BITS  (ACC_BITS),
            .COEF      (COEF_BITS'(hilb_pkg::coef_at(g, COEF_BITS))),
            .ACC_INIT  (ROUND_INIT)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_accept),
            .i_sample (w_sample),
            .i_sum    (w_sum[g+1]),
            .o_sum    (w_sum[g])
        );
    end

    hilb_delay u_delay (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_accept),
        .i_sample (w_sample),
        .o_tap    (w_direct)
    );

    // scale back and saturate
    assign w_shift = w_sum[0] >>> FRAC;
    always_comb begin
        if (w_shift > QMAX) begin
            w_quad = QMAX[SB-1:0];
        end else if (w_shift < QMIN) begin
            w_quad = QMIN[SB-1:0];
        end else begin
            w_quad = w_shift[SB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_direct <= w_direct;
            r_quad   <= w_quad;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_quad, r_direct};

    `HILB_ASSERT(a_no_accept_when_blocked, i_clk, i_rst_n, (r_valid && !i_m_tready) |-> !w_accept)
    `HILB_ASSERT(a_accept_gives_result, i_clk, i_rst_n, w_accept |=> r_valid)
    `HILB_ASSERT(a_line_holds_when_idle, i_clk, i_rst_n, (!w_accept && i_rst_n) |=> $stable(w_direct))

endmodule
